[hdl/awu_pkg.sv]
// awu_pkg: shared constants, payload structs and pipeline tag for the adagrad update unit
// no dependencies; used by every module of the block
`default_nettype none

package awu_pkg;

  localparam int ROWS        = 64;
  localparam int COLS        = 64;
  localparam int DEPTH       = ROWS * COLS;
  localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam int QUEUE_DEPTH = 4;
  localparam int Q_PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  localparam int ROOT_W      = 48;
  localparam int RAD_W       = 2 * ROOT_W;
  localparam int REM_W       = ROOT_W + 2;
  localparam int SQRT_STEPS  = ROOT_W;

  localparam int NUM_W       = 95;
  localparam int QUO_W       = 41;
  localparam int DIV_STEPS   = QUO_W;

  localparam logic [31:0]      LEARN_RATE_RESET = 32'd6554;
  localparam logic [63:0]      EPS_Q32          = 64'd43;
  localparam logic [QUO_W-1:0] UPD_LIMIT        = QUO_W'(64'd1 << 40);

  localparam logic MODE_UPDATE = 1'b0;
  localparam logic MODE_LOAD   = 1'b1;

  typedef enum logic [1:0] {
    KIND_UPDATE,
    KIND_LOAD,
    KIND_SKIP
  } item_kind_t;

  typedef struct packed {
    logic               mode;
    logic [5:0]         row_index;
    logic [5:0]         col_index;
    logic signed [31:0] prev_value;
    logic signed [31:0] grad_value;
    logic signed [31:0] weight_value;
  } req_item_t;

  typedef struct packed {
    logic signed [31:0] new_weight;
    logic [63:0]        new_cache;
    logic               saturated;
  } res_item_t;

  typedef struct packed {
    item_kind_t         kind;
    logic [IDX_W-1:0]   idx;
    logic signed [31:0] prev_value;
    logic signed [31:0] grad_value;
    logic signed [31:0] weight_value;
  } work_item_t;

  typedef struct packed {
    logic             valid;
    item_kind_t       kind;
    logic [IDX_W-1:0] idx;
    logic [31:0]      weight_value;
    logic             neg;
    logic             sat;
    logic [63:0]      cache;
  } tag_t;

endpackage

`default_nettype wire

[hdl/awu_front.sv]
// awu_front: accepts requests, range-checks the address and classifies the item
// depends on awu_pkg; feeds awu_queue
`default_nettype none

module awu_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_stall,
  input  awu_pkg::req_item_t     req_data,
  output logic                   push_valid,
  output awu_pkg::work_item_t    push_data,
  input  logic                   push_full
);

  logic                held_valid;
  awu_pkg::work_item_t held;
  awu_pkg::work_item_t classified;
  logic                in_range;

  assign req_stall  = held_valid && push_full;
  assign push_valid = held_valid;
  assign push_data  = held;

  always_comb begin
    in_range = (int'(req_data.row_index) < awu_pkg::ROWS) &&
               (int'(req_data.col_index) < awu_pkg::COLS);
    classified.idx = awu_pkg::IDX_W'(int'(req_data.row_index) * awu_pkg::COLS +
                                     int'(req_data.col_index));
    if (!in_range) begin
      classified.kind = awu_pkg::KIND_SKIP;
    end else if (req_data.mode == awu_pkg::MODE_LOAD) begin
      classified.kind = awu_pkg::KIND_LOAD;
    end else begin
      classified.kind = awu_pkg::KIND_UPDATE;
    end
    classified.prev_value   = req_data.prev_value;
    classified.grad_value   = req_data.grad_value;
    classified.weight_value = req_data.weight_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!req_stall) begin
      held_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!req_stall && req_valid) begin
      held <= classified;
    end
  end

endmodule

`default_nettype wire

[hdl/awu_queue.sv]
// awu_queue: short fifo of classified items between front and back
// depends on awu_pkg
`default_nettype none

module awu_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  input  awu_pkg::work_item_t push_data,
  output logic                full,
  input  logic                pop,
  output awu_pkg::work_item_t pop_data,
  output logic                empty
);

  awu_pkg::work_item_t            slots [awu_pkg::QUEUE_DEPTH];
  logic [awu_pkg::Q_PTR_W-1:0]    wr_ptr;
  logic [awu_pkg::Q_PTR_W-1:0]    rd_ptr;
  logic [awu_pkg::Q_CNT_W-1:0]    count;
  logic [awu_pkg::Q_CNT_W-1:0]    count_next;
  logic                           do_push;
  logic                           do_pop;

  assign full     = count == awu_pkg::Q_CNT_W'(awu_pkg::QUEUE_DEPTH);
  assign empty    = count == '0;
  assign do_push  = push_valid && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  always_comb begin
    count_next = count;
    if (do_push && !do_pop) begin
      count_next = count + awu_pkg::Q_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_next = count - awu_pkg::Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (do_push) begin
        wr_ptr <= (wr_ptr == awu_pkg::Q_PTR_W'(awu_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + awu_pkg::Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == awu_pkg::Q_PTR_W'(awu_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + awu_pkg::Q_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

[hdl/awu_sqrt.sv]
// awu_sqrt: pipelined digit-by-digit square root of a q32.32 value, one root bit per stage
// depends on awu_pkg; carries the item tag and the update numerator alongside
`default_nettype none

module awu_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  awu_pkg::tag_t               tag_in,
  input  logic [63:0]                 rad_in,
  input  logic [awu_pkg::NUM_W-1:0]   num_in,
  output awu_pkg::tag_t               tag_out,
  output logic [awu_pkg::ROOT_W-1:0]  root_out,
  output logic [awu_pkg::NUM_W-1:0]   num_out
);

  awu_pkg::tag_t                tag_q     [awu_pkg::SQRT_STEPS];
  logic [awu_pkg::REM_W-1:0]    rem_q     [awu_pkg::SQRT_STEPS];
  logic [awu_pkg::ROOT_W-1:0]   root_q    [awu_pkg::SQRT_STEPS];
  logic [awu_pkg::RAD_W-1:0]    rad_q     [awu_pkg::SQRT_STEPS];
  logic [awu_pkg::NUM_W-1:0]    num_q     [awu_pkg::SQRT_STEPS];
  logic [awu_pkg::REM_W-1:0]    rem_p     [awu_pkg::SQRT_STEPS];
  logic [awu_pkg::ROOT_W-1:0]   root_p    [awu_pkg::SQRT_STEPS];
  logic [awu_pkg::RAD_W-1:0]    rad_p     [awu_pkg::SQRT_STEPS];
  logic [awu_pkg::REM_W-1:0]    rem_next  [awu_pkg::SQRT_STEPS];
  logic [awu_pkg::ROOT_W-1:0]   root_next [awu_pkg::SQRT_STEPS];
  logic [awu_pkg::RAD_W-1:0]    rad_next  [awu_pkg::SQRT_STEPS];

  always_comb begin
    rem_p[0]  = '0;
    root_p[0] = '0;
    rad_p[0]  = {rad_in, 32'd0};
    for (int k = 1; k < awu_pkg::SQRT_STEPS; k++) begin
      rem_p[k]  = rem_q[k-1];
      root_p[k] = root_q[k-1];
      rad_p[k]  = rad_q[k-1];
    end
  end

  always_comb begin
    logic [awu_pkg::REM_W+1:0] sh;
    logic [awu_pkg::REM_W+1:0] trial;
    sh    = '0;
    trial = '0;
    for (int k = 0; k < awu_pkg::SQRT_STEPS; k++) begin
      sh    = {rem_p[k], rad_p[k][awu_pkg::RAD_W-1 -: 2]};
      trial = (awu_pkg::REM_W + 2)'({root_p[k], 2'b01});
      if (sh >= trial) begin
        rem_next[k]  = awu_pkg::REM_W'(sh - trial);
        root_next[k] = {root_p[k][awu_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_next[k]  = awu_pkg::REM_W'(sh);
        root_next[k] = {root_p[k][awu_pkg::ROOT_W-2:0], 1'b0};
      end
      rad_next[k] = {rad_p[k][awu_pkg::RAD_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < awu_pkg::SQRT_STEPS; k++) begin
        tag_q[k].valid <= 1'b0;
      end
    end else if (adv) begin
      tag_q[0] <= tag_in;
      for (int k = 1; k < awu_pkg::SQRT_STEPS; k++) begin
        tag_q[k] <= tag_q[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num_q[0] <= num_in;
      for (int k = 1; k < awu_pkg::SQRT_STEPS; k++) begin
        num_q[k] <= num_q[k-1];
      end
      for (int k = 0; k < awu_pkg::SQRT_STEPS; k++) begin
        rem_q[k]  <= rem_next[k];
        root_q[k] <= root_next[k];
        rad_q[k]  <= rad_next[k];
      end
    end
  end

  assign tag_out  = tag_q[awu_pkg::SQRT_STEPS-1];
  assign root_out = root_q[awu_pkg::SQRT_STEPS-1];
  assign num_out  = num_q[awu_pkg::SQRT_STEPS-1];

endmodule

`default_nettype wire

[hdl/awu_div.sv]
// awu_div: pipelined restoring divider, one quotient bit per stage after the first, result limited to 2^40
// depends on awu_pkg; carries the item tag alongside
`default_nettype none

module awu_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  awu_pkg::tag_t               tag_in,
  input  logic [awu_pkg::NUM_W-1:0]   num_in,
  input  logic [awu_pkg::ROOT_W-1:0]  den_in,
  output awu_pkg::tag_t               tag_out,
  output logic [awu_pkg::QUO_W-1:0]   mag_out
);

  awu_pkg::tag_t               tag_q  [awu_pkg::DIV_STEPS+1];
  logic                        over_q [awu_pkg::DIV_STEPS+1];
  logic [awu_pkg::ROOT_W-1:0]  rem_q  [awu_pkg::DIV_STEPS+1];
  logic [awu_pkg::QUO_W-1:0]   lo_q   [awu_pkg::DIV_STEPS+1];
  logic [awu_pkg::QUO_W-1:0]   quo_q  [awu_pkg::DIV_STEPS+1];
  logic [awu_pkg::ROOT_W-1:0]  den_q  [awu_pkg::DIV_STEPS+1];
  logic [awu_pkg::ROOT_W-1:0]  rem_next [awu_pkg::DIV_STEPS+1];
  logic [awu_pkg::QUO_W-1:0]   quo_next [awu_pkg::DIV_STEPS+1];
  logic                        over_in;
  logic [awu_pkg::QUO_W-1:0]   quo_last;

  // quotient at or above 2^41 is flagged up front, the steps then fit the remainder
  assign over_in = num_in[awu_pkg::NUM_W-1:awu_pkg::QUO_W] >=
                   (awu_pkg::NUM_W - awu_pkg::QUO_W)'(den_in);

  always_comb begin
    logic [awu_pkg::ROOT_W:0] sh;
    sh          = '0;
    rem_next[0] = num_in[awu_pkg::QUO_W+awu_pkg::ROOT_W-1:awu_pkg::QUO_W];
    quo_next[0] = '0;
    for (int k = 1; k <= awu_pkg::DIV_STEPS; k++) begin
      sh = {rem_q[k-1], lo_q[k-1][awu_pkg::QUO_W-1]};
      if (sh >= {1'b0, den_q[k-1]}) begin
        rem_next[k] = awu_pkg::ROOT_W'(sh - {1'b0, den_q[k-1]});
        quo_next[k] = {quo_q[k-1][awu_pkg::QUO_W-2:0], 1'b1};
      end else begin
        rem_next[k] = sh[awu_pkg::ROOT_W-1:0];
        quo_next[k] = {quo_q[k-1][awu_pkg::QUO_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= awu_pkg::DIV_STEPS; k++) begin
        tag_q[k].valid <= 1'b0;
      end
    end else if (adv) begin
      tag_q[0] <= tag_in;
      for (int k = 1; k <= awu_pkg::DIV_STEPS; k++) begin
        tag_q[k] <= tag_q[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      over_q[0] <= over_in;
      lo_q[0]   <= num_in[awu_pkg::QUO_W-1:0];
      den_q[0]  <= den_in;
      for (int k = 1; k <= awu_pkg::DIV_STEPS; k++) begin
        over_q[k] <= over_q[k-1];
        lo_q[k]   <= {lo_q[k-1][awu_pkg::QUO_W-2:0], 1'b0};
        den_q[k]  <= den_q[k-1];
      end
      for (int k = 0; k <= awu_pkg::DIV_STEPS; k++) begin
        rem_q[k] <= rem_next[k];
        quo_q[k] <= quo_next[k];
      end
    end
  end

  assign quo_last = quo_q[awu_pkg::DIV_STEPS];
  assign tag_out  = tag_q[awu_pkg::DIV_STEPS];
  assign mag_out  = (over_q[awu_pkg::DIV_STEPS] || quo_last > awu_pkg::UPD_LIMIT) ?
                    awu_pkg::UPD_LIMIT : quo_last;

endmodule

`default_nettype wire

[hdl/awu_back.sv]
// awu_back: execution pipeline with cache read-modify-write, sqrt, divide and weight write-back
// depends on awu_pkg, awu_sqrt and awu_div; holds the weight and cache memories
`default_nettype none

module awu_back (
  input  logic                clk,
  input  logic                rst,
  input  logic [31:0]         learn_rate,
  input  awu_pkg::work_item_t pop_data,
  input  logic                q_empty,
  output logic                pop,
  output logic                res_valid,
  input  logic                res_stall,
  output awu_pkg::res_item_t  res_data
);

  logic        adv;
  logic [31:0] emag;

  logic                v1;
  awu_pkg::work_item_t it1;
  awu_pkg::tag_t       tg1, tg2, tg3, tg3_d, tg4, tg5, tg6, tg7, tg7_d, tg8, tg8_d;

  logic signed [63:0] dx2;
  logic [62:0]        dm3, dm4, dm5, dm6, dm7;
  logic [63:0]        p00_4, p00_5, p00_6;
  logic [62:0]        p01_5, p01_6;
  logic [61:0]        p11_6;
  logic [125:0]       sq;
  logic               sq_over;
  logic [63:0]        sq32;
  logic [63:0]        sq7;
  logic [63:0]        mlo7, mlo8;
  logic [62:0]        mhi8;

  logic [63:0] cache_mem [awu_pkg::DEPTH];
  logic [31:0] weight_mem [awu_pkg::DEPTH];
  logic [63:0] crd;
  logic [63:0] cold;
  logic [64:0] csum;
  logic        cwr;

  logic [64:0]               vsum;
  logic [63:0]               rad8;
  logic [awu_pkg::NUM_W-1:0] num8;

  awu_pkg::tag_t              sq_tag;
  logic [awu_pkg::ROOT_W-1:0] sq_root;
  logic [awu_pkg::NUM_W-1:0]  sq_num;
  awu_pkg::tag_t              dv_tag;
  logic [awu_pkg::QUO_W-1:0]  dv_mag;

  awu_pkg::tag_t             tgw;
  logic [awu_pkg::QUO_W-1:0] magw;
  logic [31:0]               wrd;
  logic [31:0]               wold;
  logic signed [42:0]        upd;
  logic signed [42:0]        wsum;
  logic [31:0]               wnew;
  logic                      wsat;
  logic                      wwr;
  awu_pkg::res_item_t        res_d;

  logic                      fw_valid;
  logic [awu_pkg::IDX_W-1:0] fw_idx;
  logic [31:0]               fw_w;

  assign adv  = !res_valid || !res_stall;
  assign pop  = adv && !q_empty;
  assign emag = learn_rate[31] ? 32'(-learn_rate) : learn_rate;

  always_comb begin
    tg1              = '0;
    tg1.valid        = v1;
    tg1.kind         = it1.kind;
    tg1.idx          = it1.idx;
    tg1.weight_value = it1.weight_value;
  end

  always_comb begin
    tg3_d     = tg2;
    tg3_d.neg = dx2[63] ^ learn_rate[31];
  end

  // square of dx from partial products
  always_comb begin
    sq = {p11_6, 64'd0} + {30'd0, p01_6, 33'd0} + {62'd0, p00_6};
    sq_over = |sq[125:96];
    sq32    = sq_over ? '1 : sq[95:32];
    tg7_d   = tg6;
    tg7_d.sat = (tg6.kind == awu_pkg::KIND_UPDATE) && sq_over;
  end

  // cache update, forwarding the write of the item just ahead
  always_comb begin
    cold = (tg8.valid && tg8.kind != awu_pkg::KIND_SKIP && tg8.idx == tg7.idx) ?
           tg8.cache : crd;
    csum  = {1'b0, cold} + {1'b0, sq7};
    tg8_d = tg7;
    case (tg7.kind)
      awu_pkg::KIND_UPDATE: begin
        tg8_d.cache = csum[64] ? '1 : csum[63:0];
        tg8_d.sat   = tg7.sat | csum[64];
      end
      default: begin
        tg8_d.cache = '0;
        tg8_d.sat   = 1'b0;
      end
    endcase
    cwr = tg7.valid && tg7.kind != awu_pkg::KIND_SKIP;
  end

  always_comb begin
    vsum = {1'b0, tg8.cache} + {1'b0, awu_pkg::EPS_Q32};
    rad8 = vsum[64] ? '1 : vsum[63:0];
    num8 = {31'd0, mlo8} + {mhi8, 32'd0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      tg2.valid <= 1'b0;
      tg3.valid <= 1'b0;
      tg4.valid <= 1'b0;
      tg5.valid <= 1'b0;
      tg6.valid <= 1'b0;
      tg7.valid <= 1'b0;
      tg8.valid <= 1'b0;
    end else if (adv) begin
      v1  <= !q_empty;
      tg2 <= tg1;
      tg3 <= tg3_d;
      tg4 <= tg3;
      tg5 <= tg4;
      tg6 <= tg5;
      tg7 <= tg7_d;
      tg8 <= tg8_d;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it1   <= pop_data;
      dx2   <= it1.prev_value * it1.grad_value;
      dm3   <= dx2[63] ? 63'(-dx2) : dx2[62:0];
      dm4   <= dm3;
      p00_4 <= 64'(dm3[31:0]) * 64'(dm3[31:0]);
      dm5   <= dm4;
      p00_5 <= p00_4;
      p01_5 <= 63'(dm4[31:0]) * 63'(dm4[62:32]);
      dm6   <= dm5;
      p00_6 <= p00_5;
      p01_6 <= p01_5;
      p11_6 <= 62'(dm5[62:32]) * 62'(dm5[62:32]);
      dm7   <= dm6;
      sq7   <= sq32;
      mlo7  <= 64'(emag) * 64'(dm6[31:0]);
      mlo8  <= mlo7;
      mhi8  <= 63'(emag) * 63'(dm7[62:32]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      crd <= cache_mem[tg6.idx];
    end
  end

  always_ff @(posedge clk) begin
    if (adv && cwr) begin
      cache_mem[tg7.idx] <= tg8_d.cache;
    end
  end

  awu_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .tag_in   (tg8),
    .rad_in   (rad8),
    .num_in   (num8),
    .tag_out  (sq_tag),
    .root_out (sq_root),
    .num_out  (sq_num)
  );

  awu_div u_div (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .tag_in  (sq_tag),
    .num_in  (sq_num),
    .den_in  (sq_root),
    .tag_out (dv_tag),
    .mag_out (dv_mag)
  );

  // weight update, forwarding the write of the item just ahead
  always_comb begin
    wold = (fw_valid && fw_idx == tgw.idx) ? fw_w : wrd;
    upd  = tgw.neg ? -$signed({2'b00, magw}) : $signed({2'b00, magw});
    wsum = $signed({{11{wold[31]}}, wold}) + upd;
    wsat = 1'b0;
    if (wsum > 43'sd2147483647) begin
      wnew = 32'h7fff_ffff;
      wsat = 1'b1;
    end else if (wsum < -43'sd2147483648) begin
      wnew = 32'h8000_0000;
      wsat = 1'b1;
    end else begin
      wnew = wsum[31:0];
    end
    res_d = '0;
    case (tgw.kind)
      awu_pkg::KIND_UPDATE: begin
        res_d.new_weight = wnew;
        res_d.new_cache  = tgw.cache;
        res_d.saturated  = tgw.sat | wsat;
      end
      awu_pkg::KIND_LOAD: begin
        wnew             = tgw.weight_value;
        res_d.new_weight = tgw.weight_value;
      end
      default: begin
        res_d = '0;
      end
    endcase
    wwr = tgw.valid && tgw.kind != awu_pkg::KIND_SKIP;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wrd <= weight_mem[dv_tag.idx];
    end
  end

  always_ff @(posedge clk) begin
    if (adv && wwr) begin
      weight_mem[tgw.idx] <= wnew;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tgw.valid <= 1'b0;
      fw_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else if (adv) begin
      tgw       <= dv_tag;
      fw_valid  <= wwr;
      res_valid <= tgw.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      magw     <= dv_mag;
      fw_idx   <= tgw.idx;
      fw_w     <= wnew;
      res_data <= res_d;
    end
  end

endmodule

`default_nettype wire

[hdl/adagrad_weight_update_unit.sv]
// adagrad_weight_update_unit: top level, learn rate register, front, queue and back
// depends on awu_pkg, awu_front, awu_queue and awu_back
//
// Streams one request per clock while req_stall is low: each request either loads a weight
// (clearing its cache entry) or applies one adagrad step to a single entry of the 64 x 64
// weight matrix, and every request returns exactly one result, in order. Requests pass
// through the input register, queue, eight multiply and cache stages, 48 square-root
// stages (one root bit each), 42 divider stages (an input stage, then one quotient
// bit each), weight write-back and output register. Repeated hits on the same entry are
// forwarded inside the pipeline, so any address pattern runs at full rate. A result not
// taken holds the whole back pipeline; the queue of four keeps accepting requests
// meanwhile, until it fills. Write learn_rate only while no request is in flight.
`default_nettype none

module adagrad_weight_update_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  awu_pkg::req_item_t req_data,
  output logic               res_valid,
  input  logic               res_stall,
  output awu_pkg::res_item_t res_data,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_wdata
);

  logic [31:0]         learn_rate;
  logic                push_valid;
  awu_pkg::work_item_t push_data;
  logic                q_full;
  logic                q_empty;
  logic                pop;
  awu_pkg::work_item_t pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      learn_rate <= awu_pkg::LEARN_RATE_RESET;
    end else if (cfg_we) begin
      learn_rate <= cfg_wdata;
    end
  end

  awu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req_data   (req_data),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_full  (q_full)
  );

  awu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (pop),
    .pop_data   (pop_data),
    .empty      (q_empty)
  );

  awu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .learn_rate (learn_rate),
    .pop_data   (pop_data),
    .q_empty    (q_empty),
    .pop        (pop),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_data   (res_data)
  );

endmodule

`default_nettype wire
